// ===== rtl/easing_curve_evaluator_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef EASING_CURVE_EVALUATOR_UNIT_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define ECE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ECE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define ECE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ece_pkg.sv =====
package ece_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam logic [VAL_W-1:0] ONE  = VAL_W'(1) << FRAC_BITS;
   localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (FRAC_BITS - 1);
   localparam int Q30_SH    = 30 - FRAC_BITS;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_FAMILY    = 1'b0;
   localparam logic REG_DIRECTION = 1'b1;

   typedef logic [2:0] family_type;
   typedef logic [1:0] direction_type;
   typedef logic [VAL_W-1:0] value_type;

   localparam family_type FAM_SINE  = 3'd0;
   localparam family_type FAM_QUAD  = 3'd1;
   localparam family_type FAM_CUBIC = 3'd2;
   localparam family_type FAM_QUART = 3'd3;
   localparam family_type FAM_QUINT = 3'd4;
   localparam family_type FAM_CIRC  = 3'd5;
   localparam family_type FAM_EXPO  = 3'd6;

   localparam direction_type DIR_IN    = 2'd0;
   localparam direction_type DIR_OUT   = 2'd1;
   localparam direction_type DIR_INOUT = 2'd2;

   // sin(a*pi/2) odd series, Q2.30, highest order first after c11
   localparam logic [30:0] SIN_C11 = 31'd3864;
   localparam logic [30:0] SIN_COEF [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                            31'd693598668, 31'd1686629713};
   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam int EXPO_SCALE = 10;

   // floor((2^32-1)/k) for k = 10 down to 1
   localparam logic [31:0] EXP_RECIP [10] = '{32'd429496729, 32'd477218588, 32'd536870911,
                                              32'd613566756, 32'd715827882, 32'd858993459,
                                              32'd1073741823, 32'd1431655765,
                                              32'd2147483647, 32'd4294967295};

   // round-to-nearest product at the value scale
   function automatic value_type mul_fx(input value_type a, input value_type b);
      logic [2*VAL_W:0] p;
      begin
         p = (2*VAL_W+1)'(a) * (2*VAL_W+1)'(b) + ((2*VAL_W+1)'(1) << (FRAC_BITS - 1));
         return VAL_W'(p >> FRAC_BITS);
      end
   endfunction

   // round-to-nearest product in Q2.30
   function automatic logic [32:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [62:0] p;
      begin
         p = 63'(a) * 63'(b) + (63'(1) << 29);
         return 33'(p >> 30);
      end
   endfunction

endpackage

// ===== rtl/ece_req_if.sv =====
interface ece_req_if import ece_pkg::*;;
   logic      valid;
   logic      ready;
   value_type progress;
   modport source (output valid, output progress, input ready);
   modport sink (input valid, input progress, output ready);
endinterface

// ===== rtl/ece_rsp_if.sv =====
interface ece_rsp_if import ece_pkg::*;;
   logic      valid;
   logic      ready;
   value_type eased_value;
   modport source (output valid, output eased_value, input ready);
   modport sink (input valid, input eased_value, output ready);
endinterface

// ===== rtl/easing_curve_evaluator_unit.sv =====
// channel   dir  payload                 handshake
// req_chan  in   progress[16:0] Q1.16    valid/ready
// rsp_chan  out  eased_value[16:0] Q1.16 valid/ready
// csr_*     in   family @0, direction @4 apb, pready tied high
//
// one word accepted per cycle while the output word is not held; the pipeline depth
// is set by the exponential series: ten multiply/divide steps of three stages each.
// reset clears the valid bits and both csr registers.
// a held output word freezes the whole pipeline; nothing is lost or repeated.
module easing_curve_evaluator_unit import ece_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ece_req_if.sink               req_chan,
   ece_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int LAST  = 33;   // last compute stage
   localparam int OUT   = 34;   // output register
   localparam int CR_ST = 22;   // circ takes t from here
   localparam int SN_ST = 25;   // sine takes t from here
   localparam int PW_ST = 29;   // powers take t from here

   family_type    family_ff;
   direction_type direction_ff;
   logic [OUT:0]  valid_ff;
   logic          adv;

   // csr port
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff    <= FAM_SINE;
         direction_ff <= DIR_IN;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_FAMILY:    family_ff    <= csr_pwdata[2:0];
            REG_DIRECTION: direction_ff <= csr_pwdata[1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FAMILY:    csr_prdata = 32'(family_ff);
         REG_DIRECTION: csr_prdata = 32'(direction_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // pipeline moves unless the output word is held
   assign adv            = !valid_ff[OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = valid_ff[OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[OUT-1:0], req_chan.valid};
      end
   end

   // entry: saturate and fold direction into the curve argument
   value_type     x_in, t_in;
   logic          lo_in;
   logic [VAL_W:0] dbl;
   always_comb begin
      x_in  = (req_chan.progress > ONE) ? ONE : req_chan.progress;
      lo_in = x_in < HALF;
      dbl   = {x_in, 1'b0};
      unique case (direction_ff)
         DIR_OUT:   t_in = ONE - x_in;
         DIR_INOUT: t_in = lo_in ? VAL_W'(dbl) : VAL_W'({ONE, 1'b0} - dbl);
         default:   t_in = x_in;
      endcase
   end

   value_type t_ff [0:LAST];
   value_type x_ff [0:LAST];
   logic      lo_ff [0:LAST];
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0]  <= t_in;
         x_ff[0]  <= x_in;
         lo_ff[0] <= lo_in;
         for (int i = 1; i <= LAST; i++) begin
            t_ff[i]  <= t_ff[i-1];
            x_ff[i]  <= x_ff[i-1];
            lo_ff[i] <= lo_ff[i-1];
         end
      end
   end

   // powers: up to four rounded products, stages 30..33
   value_type pw_ff [4];
   logic [3:0] pw_cnt;
   assign pw_cnt = 4'(family_ff) + 4'd1;
   always_ff @(posedge clock) begin
      if (adv) begin
         pw_ff[0] <= (pw_cnt > 4'd1) ? mul_fx(t_ff[PW_ST], t_ff[PW_ST]) : t_ff[PW_ST];
         for (int k = 1; k < 4; k++) begin
            pw_ff[k] <= (pw_cnt > 4'(k + 1)) ? mul_fx(pw_ff[k-1], t_ff[PW_ST+k])
                                             : pw_ff[k-1];
         end
      end
   end

   // sine: square, five horner steps, final product, round, stages 26..33
   logic [30:0] sn_a_ff [0:6];
   logic [30:0] sn_s_ff [0:5];
   logic [30:0] sn_p_ff [0:4];
   logic [31:0] sn_v_ff;
   value_type   sn_f_ff;
   logic [30:0] sn_a_in;
   logic [17:0] sn_r;
   assign sn_a_in = 31'(ONE - t_ff[SN_ST]) << Q30_SH;
   assign sn_r    = 18'((33'(sn_v_ff) + (33'(1) << (Q30_SH - 1))) >> Q30_SH);
   always_ff @(posedge clock) begin
      if (adv) begin
         sn_a_ff[0] <= sn_a_in;
         sn_s_ff[0] <= 31'(mul_q30(sn_a_in, sn_a_in));
         for (int i = 1; i < 7; i++) sn_a_ff[i] <= sn_a_ff[i-1];
         for (int i = 1; i < 6; i++) sn_s_ff[i] <= sn_s_ff[i-1];
         sn_p_ff[0] <= SIN_COEF[0] - 31'(mul_q30(sn_s_ff[0], SIN_C11));
         for (int i = 1; i < 5; i++) begin
            sn_p_ff[i] <= SIN_COEF[i] - 31'(mul_q30(sn_s_ff[i], sn_p_ff[i-1]));
         end
         sn_v_ff <= 32'(mul_q30(sn_a_ff[5], sn_p_ff[4]));
         sn_f_ff <= ONE - ((sn_r > 18'(ONE)) ? ONE : VAL_W'(sn_r));
      end
   end

   // circ: exact square root, up to two result bits per stage, stages 23..33
   logic [33:0] cr_rem_ff [0:9];
   logic [33:0] cr_root_ff [0:9];
   value_type   cr_f_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         cr_rem_ff[0]  <= (34'(1) << (2 * FRAC_BITS)) -
                          34'(t_ff[CR_ST]) * 34'(t_ff[CR_ST]);
         cr_root_ff[0] <= '0;
         cr_f_ff       <= ONE - VAL_W'(cr_root_ff[9]);
      end
   end

   for (genvar m = 0; m < 9; m++) begin : g_sqrt
      logic [33:0] rem_in, root_in;
      always_comb begin
         logic [34:0] trial;
         logic [33:0] bit_v;
         rem_in  = cr_rem_ff[m];
         root_in = cr_root_ff[m];
         for (int j = 0; j < 2; j++) begin
            if (2 * m + j <= FRAC_BITS) begin
               bit_v = 34'(1) << (2 * FRAC_BITS - 2 * (2 * m + j));
               trial = 35'(root_in) + 35'(bit_v);
               if (35'(rem_in) >= trial) begin
                  rem_in  = 34'(35'(rem_in) - trial);
                  root_in = (root_in >> 1) + bit_v;
               end else begin
                  root_in = root_in >> 1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cr_rem_ff[m+1]  <= rem_in;
            cr_root_ff[m+1] <= root_in;
         end
      end
   end

   // expo: exponent split, ln2 scaling, ten horner steps, shift and round
   logic [19:0] ex_e;
   logic [3:0]  ex_n_ff [1:32];
   logic [29:0] ex_f_ff;
   logic [29:0] ex_g_ff [2:29];
   logic [29:0] ex_m_ff [10];
   logic [29:0] ex_mh_ff [10];
   logic [61:0] ex_prod_ff [10];
   logic [30:0] ex_p_ff [10];
   value_type   ex_out_ff;
   assign ex_e = 20'(EXPO_SCALE) * 20'(ONE - t_ff[0]);
   always_ff @(posedge clock) begin
      if (adv) begin
         ex_n_ff[1] <= ex_e[19:16];
         ex_f_ff    <= {ex_e[15:0], 14'd0};
         for (int i = 2; i <= 32; i++) ex_n_ff[i] <= ex_n_ff[i-1];
         ex_g_ff[2] <= 30'(mul_q30({1'b0, ex_f_ff}, {1'b0, LN2_Q30}));
         for (int i = 3; i <= 29; i++) ex_g_ff[i] <= ex_g_ff[i-1];
      end
   end

   for (genvar j = 0; j < 10; j++) begin : g_exp
      localparam int K = 10 - j;
      logic [30:0] p_prev;
      logic [29:0] q0, q_in;
      logic [30:0] r;
      if (j == 0) begin : g_first
         assign p_prev = Q30_ONE;
      end else begin : g_next
         assign p_prev = ex_p_ff[j-1];
      end
      assign q0   = ex_prod_ff[j][61:32];
      assign r    = 31'(ex_mh_ff[j]) - 31'(q0) * 31'(K);
      assign q_in = (r >= 31'(K)) ? q0 + 30'd1 : q0;
      always_ff @(posedge clock) begin
         if (adv) begin
            ex_m_ff[j]    <= 30'(mul_q30({1'b0, ex_g_ff[2+3*j]}, p_prev));
            ex_prod_ff[j] <= 62'(ex_m_ff[j]) * 62'(EXP_RECIP[j]);
            ex_mh_ff[j]   <= ex_m_ff[j];
            ex_p_ff[j]    <= Q30_ONE - 31'(q_in);
         end
      end
   end

   logic [4:0]  ex_sh;
   logic [31:0] ex_sum;
   assign ex_sh  = 5'(Q30_SH) + 5'(ex_n_ff[32]);
   assign ex_sum = 32'(ex_p_ff[9]) + (32'(1) << (ex_sh - 5'd1));
   always_ff @(posedge clock) begin
      if (adv) begin
         ex_out_ff <= (t_ff[32] == '0) ? '0 : VAL_W'(ex_sum >> ex_sh);
      end
   end

   // pick the family and apply the direction
   value_type f_sel, y_in, y_ff, f_half;
   always_comb begin
      unique case (family_ff)
         FAM_SINE:  f_sel = sn_f_ff;
         FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: f_sel = pw_ff[3];
         FAM_CIRC:  f_sel = cr_f_ff;
         FAM_EXPO:  f_sel = ex_out_ff;
         default:   f_sel = x_ff[LAST];
      endcase
      f_half = VAL_W'(({1'b0, f_sel} + 18'd1) >> 1);
      if (family_ff > FAM_EXPO) begin
         y_in = x_ff[LAST];
      end else begin
         unique case (direction_ff)
            DIR_IN:    y_in = f_sel;
            DIR_OUT:   y_in = ONE - f_sel;
            DIR_INOUT: y_in = lo_ff[LAST] ? f_half : ONE - f_half;
            default:   y_in = x_ff[LAST];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_in;
      end
   end
   assign rsp_chan.eased_value = y_ff;

endmodule

// ===== rtl/ece_checker.sv =====
`include "easing_curve_evaluator_unit_defines.svh"
module ece_checker import ece_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type eased_value
);

   // result never exceeds one
   `ECE_ASSERT_NOW(a_range, clock, reset, rsp_valid, eased_value <= ONE, "eased value above one")
   // a free output side always lets a word in
   `ECE_ASSERT_NOW(a_ready, clock, reset, !rsp_valid || rsp_ready, req_ready, "input stalled")
   // a held word stays put
   `ECE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(eased_value), "held word changed")
   // reset empties the pipeline
   `ECE_ASSERT_ALWAYS(a_reset, clock, reset, !rsp_valid, "output valid after reset")

endmodule

bind easing_curve_evaluator_unit ece_checker u_ece_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .eased_value (rsp_chan.eased_value)
);

// ===== sim/tb_easing_curve_evaluator_unit.sv =====
module tb_easing_curve_evaluator_unit;
   import ece_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [63:0] wide_type;

   // codes the block treats as linear
   localparam family_type    FAM_UNUSED = 3'd7;
   localparam direction_type DIR_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_FAMILY    = CSR_ADDR_W'(4 * REG_FAMILY);
   localparam logic [CSR_ADDR_W-1:0] ADDR_DIRECTION = CSR_ADDR_W'(4 * REG_DIRECTION);
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_WORDS = 32;

   typedef struct {
      family_type    fam;
      direction_type dir;
      value_type     prog;
      bit            typed;
      value_type     want;
   } curve_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ece_req_if req_if ();
   ece_rsp_if rsp_if ();

   easing_curve_evaluator_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // current csr contents as the block should hold them
   family_type    cur_fam = FAM_SINE;
   direction_type cur_dir = DIR_IN;

   value_type eased_q[$];
   bit        typed_q[$];
   value_type typed_val_q[$];
   int  errors = 0;
   int  stall = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;

   curve_row_type steer_rows[22] = '{
      '{FAM_SINE,   DIR_IN,     17'd65536,  1'b1, 17'd65536},
      '{FAM_SINE,   DIR_IN,     17'd0,      1'b0, 17'd0},
      '{FAM_SINE,   DIR_IN,     17'd131071, 1'b0, 17'd0},
      '{FAM_QUAD,   DIR_IN,     17'd0,      1'b1, 17'd0},
      '{FAM_QUAD,   DIR_IN,     17'd65536,  1'b1, 17'd65536},
      '{FAM_QUAD,   DIR_IN,     17'd100000, 1'b1, 17'd65536},
      '{FAM_CUBIC,  DIR_OUT,    17'd32768,  1'b0, 17'd0},
      '{FAM_QUART,  DIR_INOUT,  17'd32767,  1'b0, 17'd0},
      '{FAM_QUART,  DIR_INOUT,  17'd32768,  1'b0, 17'd0},
      '{FAM_QUINT,  DIR_INOUT,  17'd1,      1'b0, 17'd0},
      '{FAM_QUINT,  DIR_OUT,    17'd65535,  1'b0, 17'd0},
      '{FAM_CIRC,   DIR_IN,     17'd0,      1'b1, 17'd0},
      '{FAM_CIRC,   DIR_IN,     17'd65535,  1'b0, 17'd0},
      '{FAM_CIRC,   DIR_INOUT,  17'd49152,  1'b0, 17'd0},
      '{FAM_EXPO,   DIR_IN,     17'd0,      1'b1, 17'd0},
      '{FAM_EXPO,   DIR_IN,     17'd65536,  1'b1, 17'd65536},
      '{FAM_EXPO,   DIR_IN,     17'd1,      1'b0, 17'd0},
      '{FAM_EXPO,   DIR_OUT,    17'd0,      1'b0, 17'd0},
      '{FAM_EXPO,   DIR_INOUT,  17'd32768,  1'b0, 17'd0},
      '{FAM_UNUSED, DIR_IN,     17'd131071, 1'b1, 17'd65536},
      '{FAM_QUAD,   DIR_UNUSED, 17'd12345,  1'b1, 17'd12345},
      '{FAM_SINE,   DIR_INOUT,  17'd21845,  1'b0, 17'd0}
   };

   // rounded q2.30 product
   function automatic wide_type q30_product(input wide_type a, input wide_type b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic wide_type fx_product(input wide_type a, input wide_type b);
      return (a * b + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   endfunction

   // sin(a*pi/2), odd series
   function automatic wide_type quarter_sine(input wide_type a);
      wide_type a30, sq, acc, v;
      a30 = a << Q30_SH;
      sq  = q30_product(a30, a30);
      acc = wide_type'(SIN_C11);
      for (int i = 0; i < 5; i++) acc = wide_type'(SIN_COEF[i]) - q30_product(sq, acc);
      v = q30_product(a30, acc);
      v = (v + (64'd1 << (Q30_SH - 1))) >> Q30_SH;
      return (v > wide_type'(ONE)) ? wide_type'(ONE) : v;
   endfunction

   function automatic wide_type int_sqrt(input wide_type v);
      wide_type root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // 2^-e, e in value units
   function automatic wide_type neg_pow2(input wide_type e);
      wide_type whole, f30, g, acc;
      int sh;
      whole = e >> FRAC_BITS;
      f30 = (e & (wide_type'(ONE) - 1)) << Q30_SH;
      g = q30_product(f30, wide_type'(LN2_Q30));
      acc = wide_type'(Q30_ONE);
      for (int k = 10; k >= 1; k--) acc = wide_type'(Q30_ONE) - q30_product(g, acc) / k;
      if (whole > 10) whole = 10;
      sh = Q30_SH + int'(whole);
      return (acc + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic wide_type curve_in(input family_type fam, input wide_type t);
      wide_type one_w;
      one_w = wide_type'(ONE);
      case (fam)
         FAM_SINE:  return one_w - quarter_sine(one_w - t);
         FAM_QUAD:  return fx_product(t, t);
         FAM_CUBIC: return fx_product(fx_product(t, t), t);
         FAM_QUART: return fx_product(fx_product(fx_product(t, t), t), t);
         FAM_QUINT: return fx_product(fx_product(fx_product(fx_product(t, t), t), t), t);
         FAM_CIRC:  return one_w - int_sqrt(one_w * one_w - t * t);
         default: begin
            if (t == 0) return 0;
            return neg_pow2(EXPO_SCALE * (one_w - t));
         end
      endcase
   endfunction

   function automatic value_type eased_value_of(input family_type fam,
                                                input direction_type dir,
                                                input value_type prog);
      wide_type x, y, one_w;
      one_w = wide_type'(ONE);
      x = (prog > ONE) ? one_w : wide_type'(prog);
      if (fam == FAM_UNUSED || dir == DIR_UNUSED) y = x;
      else if (dir == DIR_IN) y = curve_in(fam, x);
      else if (dir == DIR_OUT) y = one_w - curve_in(fam, one_w - x);
      else if (x < wide_type'(HALF)) y = (curve_in(fam, 2 * x) + 1) >> 1;
      else y = one_w - ((curve_in(fam, 2 * one_w - 2 * x) + 1) >> 1);
      return value_type'(y);
   endfunction

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // word tracking on both channels
   always @(posedge clock) begin
      if (reset) begin
         stall <= 0;
      end else begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stall <= 0;
         else stall <= stall + 1;
         if (req_if.valid && req_if.ready) begin
            if (typed_q.pop_front()) eased_q.push_back(typed_val_q.pop_front());
            else begin
               void'(typed_val_q.pop_front());
               eased_q.push_back(eased_value_of(cur_fam, cur_dir, req_if.progress));
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (eased_q.size() == 0) report_mismatch("unexpected word", rsp_if.eased_value, 0);
            else begin
               value_type want;
               want = eased_q.pop_front();
               if (rsp_if.eased_value !== want)
                  report_mismatch("eased_value", rsp_if.eased_value, want);
            end
         end
         if (stall == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result side readiness, with one long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (eased_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_curve(input family_type fam, input direction_type dir);
      logic [31:0] junk;
      if (fam != cur_fam || dir != cur_dir) begin
         wait_drained();
         junk = $urandom;
         csr_write(ADDR_FAMILY, {junk[31:3], fam});
         cur_fam = fam;
         junk = $urandom;
         csr_write(ADDR_DIRECTION, {junk[31:2], dir});
         cur_dir = dir;
      end
   endtask

   // offer one word, called and returning at a falling edge
   task automatic send_word(input value_type prog, input bit typed, input value_type want);
      while (!calm && $urandom_range(99) < 9) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      typed_q.push_back(typed);
      typed_val_q.push_back(want);
      req_if.valid <= 1'b1;
      req_if.progress <= prog;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   function automatic value_type random_progress();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 10) return ONE;
      if (r < 16) return value_type'($urandom_range(131071, 65537));
      if (r < 22) return value_type'($urandom_range(32778, 32758));
      return value_type'($urandom_range(65535));
   endfunction

   initial begin
      family_type    fam;
      direction_type dir;
      req_if.valid = 1'b0;
      req_if.progress = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      foreach (steer_rows[i]) begin
         set_curve(steer_rows[i].fam, steer_rows[i].dir);
         send_word(steer_rows[i].prog, steer_rows[i].typed, steer_rows[i].want);
      end

      // random phases over every setting and the linear codes
      for (int p = 0; p < 23; p++) begin
         if (p < 21) begin
            fam = family_type'(p / 3);
            dir = direction_type'(p % 3);
         end else begin
            fam = (p == 21) ? FAM_UNUSED : family_type'($urandom_range(6));
            dir = (p == 21) ? direction_type'($urandom_range(2)) : DIR_UNUSED;
         end
         set_curve(fam, dir);
         calm = (p == 5);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 8 && n == 3) hold_req = 1'b1;
            if (p == 12 && n == 10) wait_drained();
            send_word(random_progress(), 1'b0, '0);
         end
      end
      calm = 1'b0;
      wait_drained();
      repeat (50) @(negedge clock);
      if (errors == 0 && eased_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
